// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_ANY(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/svs_pkg.sv =====
package svs_pkg;

   localparam int MAX_VERTS = 4;
   localparam int NUM_LANES = 4;

   typedef logic [30:0] vid_type;
   typedef logic [2:0]  count_type;
   typedef logic [1:0]  pos_type;
   typedef logic [7:0]  key_type;

   localparam count_type COUNT_RESET = 3'd4;
   localparam count_type COUNT_MIN   = 3'd2;

   // Clamp the raw register value into the supported range of vertices.
   function automatic count_type eff_count(input count_type raw);
      count_type n;
      n = raw;
      if (n < COUNT_MIN) n = COUNT_MIN;
      if (n > count_type'(MAX_VERTS)) n = count_type'(MAX_VERTS);
      return n;
   endfunction

endpackage

// ===== sv/svs_if.sv =====
interface svs_req_if;
   logic              valid;
   logic              ready;
   svs_pkg::vid_type  vert_a;
   svs_pkg::vid_type  vert_b;
   svs_pkg::vid_type  vert_c;
   svs_pkg::vid_type  vert_d;

   modport source (output valid, vert_a, vert_b, vert_c, vert_d, input ready);
   modport sink   (input valid, vert_a, vert_b, vert_c, vert_d, output ready);
endinterface

interface svs_rsp_if;
   logic              valid;
   logic              ready;
   svs_pkg::vid_type  sorted_a;
   svs_pkg::vid_type  sorted_b;
   svs_pkg::vid_type  sorted_c;
   svs_pkg::vid_type  sorted_d;
   svs_pkg::key_type  perm_key;

   modport source (output valid, sorted_a, sorted_b, sorted_c, sorted_d, perm_key,
                   input ready);
   modport sink   (input valid, sorted_a, sorted_b, sorted_c, sorted_d, perm_key,
                   output ready);
endinterface

interface svs_csr_if;
   logic                valid;
   logic                ready;
   svs_pkg::count_type  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== sv/simplex_vertex_sort_with_perm_key_core.sv =====
// Sorts the 2, 3 or 4 vertex IDs of one simplex cell and returns a permutation key.
//
// req: one transaction carries vert_a..vert_d, the IDs at original positions 0..3.
// rsp: one transaction carries sorted_a..sorted_d (ascending, ties by position)
//      and perm_key, the original positions of the sorted IDs as base-n digits,
//      first sorted lane most significant. Lanes at or above n read zero.
// csr: one transaction writes vertex_count (3 bits). Values below 2 act as 2,
//      values above 4 act as 4. Write it only while no transaction is in flight.
//
// Four register stages: pairwise compare, rank count, scatter by rank, key build
// into the output register, and one request is taken every cycle while rsp keeps up.
// When rsp stalls, the stages fill behind the output register and req.ready
// drops only once every stage holds an item; nothing is dropped or repeated.
// Synchronous reset empties all stages and sets vertex_count to 4.
module simplex_vertex_sort_with_perm_key_core (
   input  logic        clock,
   input  logic        reset,
   svs_req_if.sink     req,
   svs_rsp_if.source   rsp,
   svs_csr_if.sink     csr
);

   localparam int NL = svs_pkg::NUM_LANES;

   svs_pkg::count_type vertex_count_ff;

   // Stage 1: bit [i][j] is set when lane i sorts before lane j
   logic                       s1_valid_ff;
   logic [NL-1:0][NL-1:0]      s1_before_ff, s1_before_in;
   svs_pkg::vid_type [NL-1:0]  s1_vert_ff;
   svs_pkg::count_type         s1_n_ff;
   logic [NL-1:0]              s1_lane_en_ff, s1_lane_en_in;
   svs_pkg::count_type         n_in;

   // Stage 2: rank per lane
   logic                       s2_valid_ff;
   svs_pkg::pos_type [NL-1:0]  s2_rank_ff, s2_rank_in;
   svs_pkg::vid_type [NL-1:0]  s2_vert_ff;
   svs_pkg::count_type         s2_n_ff;
   logic [NL-1:0]              s2_lane_en_ff;

   // Stage 3: sorted IDs and source positions
   logic                       s3_valid_ff;
   svs_pkg::vid_type [NL-1:0]  s3_sorted_ff, s3_sorted_in;
   svs_pkg::pos_type [NL-1:0]  s3_pos_ff, s3_pos_in;
   svs_pkg::count_type         s3_n_ff;

   // Stage 4: output register
   logic                       out_valid_ff;
   svs_pkg::vid_type [NL-1:0]  out_sorted_ff;
   svs_pkg::key_type           out_key_ff, out_key_in;

   logic out_ready, s3_ready, s2_ready, s1_ready;

   assign out_ready = !out_valid_ff || rsp.ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;

   assign req.ready = s1_ready;
   assign csr.ready = 1'b1;

   assign rsp.valid    = out_valid_ff;
   assign rsp.sorted_a = out_sorted_ff[0];
   assign rsp.sorted_b = out_sorted_ff[1];
   assign rsp.sorted_c = out_sorted_ff[2];
   assign rsp.sorted_d = out_sorted_ff[3];
   assign rsp.perm_key = out_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= svs_pkg::COUNT_RESET;
      end else if (csr.valid) begin
         vertex_count_ff <= csr.data;
      end
   end

   // Stage 1: six comparators fill the precedence matrix
   always_comb begin
      svs_pkg::vid_type v [NL];
      logic le;
      v[0] = req.vert_a;
      v[1] = req.vert_b;
      v[2] = req.vert_c;
      v[3] = req.vert_d;
      n_in = svs_pkg::eff_count(vertex_count_ff);
      s1_before_in = '0;
      for (int i = 0; i < NL; i++) begin
         s1_lane_en_in[i] = (svs_pkg::count_type'(i) < n_in);
      end
      for (int i = 0; i < NL; i++) begin
         for (int j = i + 1; j < NL; j++) begin
            le = (v[i] <= v[j]);
            // lower position wins a tie
            s1_before_in[i][j] = le && s1_lane_en_in[i];
            s1_before_in[j][i] = !le && s1_lane_en_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req.valid) begin
         s1_before_ff  <= s1_before_in;
         s1_vert_ff[0] <= req.vert_a;
         s1_vert_ff[1] <= req.vert_b;
         s1_vert_ff[2] <= req.vert_c;
         s1_vert_ff[3] <= req.vert_d;
         s1_n_ff       <= n_in;
         s1_lane_en_ff <= s1_lane_en_in;
      end
   end

   // Stage 2: rank is the count of lanes that sort before this one
   always_comb begin
      for (int i = 0; i < NL; i++) begin
         s2_rank_in[i] = '0;
         for (int j = 0; j < NL; j++) begin
            s2_rank_in[i] = s2_rank_in[i] + svs_pkg::pos_type'(s1_before_ff[j][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_rank_ff    <= s2_rank_in;
         s2_vert_ff    <= s1_vert_ff;
         s2_n_ff       <= s1_n_ff;
         s2_lane_en_ff <= s1_lane_en_ff;
      end
   end

   // Stage 3: scatter each live lane to the slot named by its rank
   always_comb begin
      for (int k = 0; k < NL; k++) begin
         s3_sorted_in[k] = '0;
         s3_pos_in[k]    = '0;
         for (int i = 0; i < NL; i++) begin
            if (s2_lane_en_ff[i] && (s2_rank_ff[i] == svs_pkg::pos_type'(k))) begin
               s3_sorted_in[k] = s2_vert_ff[i];
               s3_pos_in[k]    = svs_pkg::pos_type'(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_sorted_ff <= s3_sorted_in;
         s3_pos_ff    <= s3_pos_in;
         s3_n_ff      <= s2_n_ff;
      end
   end

   // Stage 4: pack positions as base-n digits
   always_comb begin
      case (s3_n_ff)
         3'd2: out_key_in = {5'd0, s3_pos_ff[0][0], s3_pos_ff[1][0]};
         3'd3: out_key_in = svs_pkg::key_type'(s3_pos_ff[0]) * 8'd9
                          + svs_pkg::key_type'(s3_pos_ff[1]) * 8'd3
                          + svs_pkg::key_type'(s3_pos_ff[2]);
         default: out_key_in = {s3_pos_ff[0], s3_pos_ff[1], s3_pos_ff[2], s3_pos_ff[3]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid_ff) begin
         out_sorted_ff <= s3_sorted_ff;
         out_key_ff    <= out_key_in;
      end
   end

endmodule

// ===== sv/svs_checker.sv =====
`include "assert_macros.svh"

module svs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input svs_pkg::vid_type   sorted_a,
   input svs_pkg::vid_type   sorted_b,
   input svs_pkg::vid_type   sorted_c,
   input svs_pkg::key_type   perm_key
);

   // hold a stalled transaction
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(sorted_a) && $stable(sorted_b) && $stable(perm_key))
   // sorted_a..sorted_c come out ascending (b to c only where sorted_c is nonzero)
   `ASSERT_IMP(a_order_ab, clock, reset, rsp_valid, sorted_a <= sorted_b)
   `ASSERT_IMP(a_order_bc, clock, reset, rsp_valid && (sorted_c != '0), sorted_b <= sorted_c)
   // reset empties the pipeline
   `ASSERT_NXT_ANY(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind simplex_vertex_sort_with_perm_key_core svs_checker u_svs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .sorted_a  (rsp.sorted_a),
   .sorted_b  (rsp.sorted_b),
   .sorted_c  (rsp.sorted_c),
   .perm_key  (rsp.perm_key)
);

// ===== bench/vertex_order_checker.sv =====
`timescale 1ns / 100ps

module vertex_order_checker (
   input  logic clock,
   input  logic reset,
   svs_req_if   req,
   svs_rsp_if   rsp,
   svs_csr_if   csr,
   output int   mismatch_count,
   output int   expected_left
);

   typedef struct {
      svs_pkg::vid_type lane [svs_pkg::NUM_LANES];
      svs_pkg::key_type key;
   } cell_order_type;

   svs_pkg::count_type vertex_count;
   cell_order_type     pending_orderings [$];

   // Stable sort of the live lanes; lanes at or above the count read zero.
   function automatic cell_order_type order_cell_vertices(
         input svs_pkg::vid_type   verts [svs_pkg::NUM_LANES],
         input svs_pkg::count_type raw_count);
      cell_order_type result;
      int             live;
      int             order [svs_pkg::NUM_LANES];
      int             swap;
      int             key;
      live = raw_count;
      if (live < 2) live = 2;
      if (live > svs_pkg::MAX_VERTS) live = svs_pkg::MAX_VERTS;
      for (int i = 0; i < svs_pkg::NUM_LANES; i++) order[i] = i;
      // strict compare keeps the lower position first on ties
      for (int i = 1; i < live; i++) begin
         for (int j = i; j > 0 && verts[order[j]] < verts[order[j-1]]; j--) begin
            swap       = order[j];
            order[j]   = order[j-1];
            order[j-1] = swap;
         end
      end
      key = 0;
      for (int i = 0; i < svs_pkg::NUM_LANES; i++) begin
         if (i < live) begin
            result.lane[i] = verts[order[i]];
            key = key * live + order[i];
         end else begin
            result.lane[i] = '0;
         end
      end
      result.key = svs_pkg::key_type'(key);
      return result;
   endfunction

   always @(posedge clock) begin
      cell_order_type   want;
      svs_pkg::vid_type verts [svs_pkg::NUM_LANES];
      svs_pkg::vid_type got [svs_pkg::NUM_LANES];
      if (reset) begin
         vertex_count <= svs_pkg::COUNT_RESET;
         mismatch_count = 0;
         pending_orderings.delete();
      end else begin
         if (csr.valid && csr.ready) vertex_count <= csr.data;
         // retire before queuing so an early result cannot match a new request
         if (rsp.valid && rsp.ready) begin
            got[0] = rsp.sorted_a;
            got[1] = rsp.sorted_b;
            got[2] = rsp.sorted_c;
            got[3] = rsp.sorted_d;
            if (pending_orderings.size() == 0) begin
               $display("%0t: result with no transaction pending, sorted_a %h perm_key %h",
                        $time, rsp.sorted_a, rsp.perm_key);
               mismatch_count++;
            end else begin
               want = pending_orderings.pop_front();
               for (int i = 0; i < svs_pkg::NUM_LANES; i++) begin
                  if (got[i] !== want.lane[i]) begin
                     $display("%0t: sorted lane %0d expected %h actual %h",
                              $time, i, want.lane[i], got[i]);
                     mismatch_count++;
                  end
               end
               if (rsp.perm_key !== want.key) begin
                  $display("%0t: perm_key expected %h actual %h",
                           $time, want.key, rsp.perm_key);
                  mismatch_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            verts[0] = req.vert_a;
            verts[1] = req.vert_b;
            verts[2] = req.vert_c;
            verts[3] = req.vert_d;
            pending_orderings.push_back(order_cell_vertices(verts, vertex_count));
         end
      end
      expected_left <= pending_orderings.size();
   end

endmodule

// ===== bench/simplex_vertex_sort_with_perm_key_core_tb.sv =====
`timescale 1ns / 100ps

module simplex_vertex_sort_with_perm_key_core_tb;

   localparam svs_pkg::vid_type VID_MAX = '1;
   localparam int CELLS_PER_SEGMENT = 110;
   localparam int SEGMENTS_PER_PHASE = 5;
   localparam svs_pkg::count_type COUNT_PLAN [15] = '{
      3'd2, 3'd3, 3'd4, 3'd0, 3'd4,
      3'd7, 3'd3, 3'd2, 3'd1, 3'd4,
      3'd5, 3'd4, 3'd2, 3'd6, 3'd3
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 23;
   int   recv_idle_pct = 56;
   int   mismatch_count;
   int   expected_left;

   always #5 clock = ~clock;

   svs_req_if req_ch ();
   svs_rsp_if rsp_ch ();
   svs_csr_if csr_ch ();

   simplex_vertex_sort_with_perm_key_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   vertex_order_checker order_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr            (csr_ch),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left)
   );

   // Many small values so ties are common, some near the top of the range, the rest random.
   function automatic svs_pkg::vid_type rand_vid();
      case ($urandom_range(9))
         0, 1, 2, 3: return svs_pkg::vid_type'($urandom_range(7));
         4:          return VID_MAX - svs_pkg::vid_type'($urandom_range(3));
         default:    return svs_pkg::vid_type'($urandom);
      endcase
   endfunction

   task automatic send_cell(input svs_pkg::vid_type a, input svs_pkg::vid_type b,
                            input svs_pkg::vid_type c, input svs_pkg::vid_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.vert_a <= a;
      req_ch.vert_b <= b;
      req_ch.vert_c <= c;
      req_ch.vert_d <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drain the pipe before touching the count.
   task automatic write_count(input svs_pkg::count_type value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Result sink, with long hold-offs that back the pipe up into req.
   initial begin
      int hold_left;
      int rsp_seen;
      int next_hold_at;
      hold_left    = 0;
      rsp_seen     = 0;
      next_hold_at = 300;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) rsp_seen++;
         if (hold_left == 0 && rsp_seen >= next_hold_at) begin
            hold_left    = 48;
            next_hold_at = next_hold_at + 1100;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      req_ch.valid  <= 1'b0;
      req_ch.vert_a <= '0;
      req_ch.vert_b <= '0;
      req_ch.vert_c <= '0;
      req_ch.vert_d <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset count of four: extremes, both orders, ties.
      send_cell(0, 0, 0, 0);
      send_cell(VID_MAX, VID_MAX, VID_MAX, VID_MAX);
      send_cell(3, 2, 1, 0);
      send_cell(0, 1, 2, 3);
      send_cell(VID_MAX, 0, VID_MAX, 0);
      send_cell(7, 7, 2, 2);
      send_cell(5, 1, 5, 1);
      send_cell(VID_MAX, 1, 0, VID_MAX - svs_pkg::vid_type'(1));

      // Upper lanes must be ignored and read zero.
      write_count(3'd2);
      send_cell(9, 3, VID_MAX, VID_MAX);
      send_cell(4, 4, 1, 2);
      send_cell(VID_MAX, 0, 0, 0);

      write_count(3'd3);
      send_cell(2, 9, 1, VID_MAX);
      send_cell(6, 6, 6, 0);
      send_cell(0, VID_MAX, 5, 1);

      // Out-of-range counts clamp to two and four.
      write_count(3'd0);
      send_cell(8, 2, 7, 7);
      send_cell(1, 1, 0, 0);
      write_count(3'd1);
      send_cell(VID_MAX, 3, 3, 3);
      write_count(3'd5);
      send_cell(4, 3, 2, 1);
      send_cell(2, 2, 2, 1);
      write_count(3'd7);
      send_cell(1, 0, 3, 2);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 23; recv_idle_pct = 56; end
            1: begin send_idle_pct = 56; recv_idle_pct = 23; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
            write_count(COUNT_PLAN[phase * SEGMENTS_PER_PHASE + seg]);
            repeat (CELLS_PER_SEGMENT) send_cell(rand_vid(), rand_vid(), rand_vid(), rand_vid());
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
